@@ sv/eeg_sample_packet_framer_assert.svh @@
// ----------------------------------------------------------------------------
// EEG sample packet framer assertion macros
// Short forms for the concurrent checks used by the framer top level.
// ----------------------------------------------------------------------------
`ifndef EEG_SAMPLE_PACKET_FRAMER_ASSERT_SVH
`define EEG_SAMPLE_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ESPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ESPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/espf_pkg.sv @@
// ----------------------------------------------------------------------------
// espf_pkg
// Shared constants and the packet job type of the EEG sample packet framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package espf_pkg;

  localparam int unsigned MAX_CHANNELS      = 8;
  localparam int unsigned CHANNEL_COUNT_DEF = 8;
  localparam int unsigned CHAN_W            = 24;
  localparam int unsigned CHAN_BYTES        = 3;
  localparam int unsigned COUNT_BYTES       = 8;
  localparam int unsigned TAG_BYTES         = 10;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hBB;

  // Frame mode codes
  localparam logic MODE_FRAMED = 1'b0;
  localparam logic MODE_RAW    = 1'b1;

  // One sample's worth of packet content, handed from front to back
  typedef struct packed {
    logic [MAX_CHANNELS-1:0][CHAN_W-1:0] chans;
    logic [63:0]                         count;
    logic [7:0]                          freq;
    logic [63:0]                         latency;
    logic [7:0]                          event_num;
    logic                                mode;
  } espf_job_t;

endpackage

@@ sv/espf_front.sv @@
// ----------------------------------------------------------------------------
// espf_front
// Accepts samples, keeps the sample counter and tag state, builds packet jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module espf_front
  import espf_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] in_chans,
  input  logic                                in_tag_request,
  input  logic [7:0]                          in_tag_frequency,
  input  logic                                q_full,
  output logic                                q_push,
  output espf_job_t                           q_job
);

  logic        frame_mode_r, frame_mode_nxt;
  logic [63:0] sample_count_r, sample_count_nxt;
  logic [7:0]  event_number_r, event_number_nxt;
  logic [7:0]  held_frequency_r, held_frequency_nxt;
  logic [63:0] held_latency_r, held_latency_nxt;

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Frame mode write, and counter and tag update for an accepted transaction
  always_comb begin
    frame_mode_nxt     = cfg_wr_en ? cfg_wr_data : frame_mode_r;
    sample_count_nxt   = sample_count_r;
    event_number_nxt   = event_number_r;
    held_frequency_nxt = held_frequency_r;
    held_latency_nxt   = held_latency_r;
    if (q_push) begin
      sample_count_nxt = sample_count_r + 64'd1;
      if (in_tag_request) begin
        held_frequency_nxt = in_tag_frequency;
        event_number_nxt   = event_number_r + 8'd1;
        held_latency_nxt   = sample_count_nxt;
      end
    end
  end

  // Job carries the post-update counter and tag state; unused channel lanes are zeroed
  always_comb begin
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      q_job.chans[ch] = (ch < CHANNEL_COUNT) ? in_chans[ch] : '0;
    end
    q_job.count     = sample_count_nxt;
    q_job.freq      = held_frequency_nxt;
    q_job.latency   = held_latency_nxt;
    q_job.event_num = event_number_nxt;
    q_job.mode      = frame_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r     <= MODE_FRAMED;
      sample_count_r   <= '0;
      event_number_r   <= '0;
      held_frequency_r <= '0;
      held_latency_r   <= '0;
    end else begin
      frame_mode_r     <= frame_mode_nxt;
      sample_count_r   <= sample_count_nxt;
      event_number_r   <= event_number_nxt;
      held_frequency_r <= held_frequency_nxt;
      held_latency_r   <= held_latency_nxt;
    end
  end

endmodule

@@ sv/espf_queue.sv @@
// ----------------------------------------------------------------------------
// espf_queue
// Short job queue that decouples sample acceptance from byte serialization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module espf_queue
  import espf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  espf_job_t                  push_job,
  input  logic                       pop,
  output logic                       full,
  output logic                       not_empty,
  output espf_job_t                  head_job,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  espf_job_t          entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = entries_r[rd_ptr_r];
  assign count     = count_r;

  // Pointer and occupancy bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ sv/espf_back.sv @@
// ----------------------------------------------------------------------------
// espf_back
// Serializes the head job into packet bytes through a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module espf_back
  import espf_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  espf_job_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      out_last_byte
);

  localparam int unsigned CH_BYTES  = CHAN_BYTES * CHANNEL_COUNT;
  localparam int unsigned FRAME_LEN = CH_BYTES + COUNT_BYTES + TAG_BYTES + 2;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);
  localparam int unsigned CNT_BASE  = 1 + CH_BYTES;
  localparam int unsigned FREQ_POS  = CNT_BASE + COUNT_BYTES;
  localparam int unsigned LAT_BASE  = FREQ_POS + 1;
  localparam int unsigned EVT_POS   = LAT_BASE + COUNT_BYTES;
  localparam int unsigned TAIL_POS  = EVT_POS + 1;

  logic [7:0]       frame [FRAME_LEN];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] last_pos;
  logic             at_last;
  logic             load;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  // Full framed layout of the head job; raw mode sends only the channel bytes
  always_comb begin
    frame[0] = HEAD_BYTE;
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      for (int b = 0; b < CHAN_BYTES; b++) begin
        frame[1 + CHAN_BYTES*ch + b] = q_head.chans[ch][CHAN_W-1-8*b -: 8];
      end
    end
    for (int i = 0; i < COUNT_BYTES; i++) begin
      frame[CNT_BASE + i] = q_head.count[63-8*i -: 8];
      frame[LAT_BASE + i] = q_head.latency[63-8*i -: 8];
    end
    frame[FREQ_POS] = q_head.freq;
    frame[EVT_POS]  = q_head.event_num;
    frame[TAIL_POS] = TAIL_BYTE;
  end

  // Position within the packet for the head job
  assign cur_pos  = pos_r + POS_W'(q_head.mode == MODE_RAW);
  assign last_pos = (q_head.mode == MODE_RAW) ? POS_W'(CH_BYTES) : POS_W'(FRAME_LEN-1);
  assign at_last  = (cur_pos == last_pos);

  // Output register loads when a job is queued and the register is empty or being taken
  assign load  = q_not_empty && (!out_valid_r || !out_stall);
  assign q_pop = load && at_last;

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      pos_nxt       = at_last ? '0 : pos_r + POS_W'(1);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= frame[cur_pos];
      out_last_r <= at_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

@@ sv/eeg_sample_packet_framer.sv @@
// ----------------------------------------------------------------------------
// eeg_sample_packet_framer
// Frames EEG converter samples into byte packets with counter and event tag.
// ----------------------------------------------------------------------------
// Each accepted sample produces one packet, one byte per output transaction:
// 3*CHANNEL_COUNT+20 bytes in framed mode (44 with eight channels) or
// 3*CHANNEL_COUNT bytes in raw mode, with out_last_byte on the final byte.
// The byte serializer sets the rate: one byte per cycle while the output is
// not stalled. Samples are accepted into a two-entry job queue, so a new
// sample can be taken while the previous packet is still going out; in_stall
// rises only when the queue is full. Write frame_mode only when idle.
`timescale 1ns / 1ps

module eeg_sample_packet_framer
  import espf_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_chan_one,
  input  logic [23:0] in_chan_two,
  input  logic [23:0] in_chan_three,
  input  logic [23:0] in_chan_four,
  input  logic [23:0] in_chan_five,
  input  logic [23:0] in_chan_six,
  input  logic [23:0] in_chan_seven,
  input  logic [23:0] in_chan_eight,
  input  logic        in_tag_request,
  input  logic [7:0]  in_tag_frequency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

`include "eeg_sample_packet_framer_assert.svh"

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] chans;
  espf_job_t                           push_job;
  espf_job_t                           head_job;
  logic                                q_push;
  logic                                q_pop;
  logic                                q_full;
  logic                                q_not_empty;
  logic [CNT_W-1:0]                    q_count;

  assign chans = {in_chan_eight, in_chan_seven, in_chan_six, in_chan_five,
                  in_chan_four, in_chan_three, in_chan_two, in_chan_one};

  espf_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_chans        (chans),
    .in_tag_request  (in_tag_request),
    .in_tag_frequency(in_tag_frequency),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  espf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_job (head_job),
    .count    (q_count)
  );

  espf_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

  // An accepted sample is queued until its last byte is loaded into the output register
  `ESPF_ASSERT_NEXT(a_push_held, in_valid && !in_stall, q_count != '0, "accepted sample not queued")

  // With nothing queued and the output free, no byte may appear
  `ESPF_ASSERT_NEXT(a_no_phantom, (q_count == '0) && (!out_valid || !out_stall), !out_valid, "byte without queued sample")

  // Queue occupancy stays within its depth
  `ESPF_ASSERT_NOW(a_count_range, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

  // Popping an empty queue would lose job alignment
  `ESPF_ASSERT_NOW(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")

endmodule
